FILE: design/cht_pkg.sv
package cht_pkg;
    localparam int BUCKETS = 256;
    localparam int ENTRIES = 1024;
    localparam int BW = $clog2(BUCKETS);
    localparam int SW = $clog2(ENTRIES);
    localparam int PW = SW + 1;
    localparam logic [PW-1:0] NIL = PW'(ENTRIES);
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ACT_GET      = 3'd0,
        ACT_GET_ONES = 3'd1,
        ACT_PUT      = 3'd2,
        ACT_PUT_NEW  = 3'd3,
        ACT_INCR     = 3'd4,
        ACT_REMOVE   = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_RD, S_CMP, S_UPD, S_FREE, S_DONE
    } t_state;
endpackage

FILE: design/cht_ram.sv
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/chained_hash_table_core.sv
// Chained hash table: 32-bit key to 32-bit value store, separate chaining over a
// pool of ENTRIES slots, bucket = key low bits. One request at a time: after reset
// a clearing pass over all BUCKETS heads nulls them (s_axis_tready low). From
// acceptance a request fetches the bucket head, then for each chain entry does one
// read of the shared key/value/link memories and one key compare, on a miss takes
// one more step to see the end of the chain, then updates (with a second update
// step, S_FREE, for a remove of a present key or an insert that reuses a freed slot)
// and posts the result; unused action codes skip straight to posting it. The result
// sits in an output register and is held until taken; the input opens again the
// cycle after it is taken.
module chained_hash_table_core import cht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // action[2:0], key[34:3], value[66:35], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // found[0], result_value[32:1], status[33],
                                       // entry_count[44:34], zero pad
);
    t_state r_state, n_state;
    logic [2:0]    r_act;
    logic [31:0]   r_key, r_val;
    logic [PW-1:0] r_cur, r_prev, r_free, r_unused, r_count;
    logic [SW:0]   r_steps;
    logic [BW-1:0] r_clr;
    logic          r_found, r_status, r_ovalid;
    logic [31:0]   r_res;

    // bucket head memory
    logic          hd_we;
    logic [BW-1:0] hd_wa, hd_ra;
    logic [PW-1:0] hd_wd, hd_rd;
    // entry memories
    logic          k_we, v_we, l_we;
    logic [SW-1:0] k_wa, v_wa, l_wa, e_ra;
    logic [31:0]   k_wd, v_wd, k_rd, v_rd;
    logic [PW-1:0] l_wd, l_rd;

    cht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (.i_clk, .i_we(hd_we), .i_waddr(hd_wa),
        .i_wdata(hd_wd), .i_raddr(hd_ra), .o_rdata(hd_rd));
    cht_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_keys (.i_clk, .i_we(k_we), .i_waddr(k_wa),
        .i_wdata(k_wd), .i_raddr(e_ra), .o_rdata(k_rd));
    cht_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_vals (.i_clk, .i_we(v_we), .i_waddr(v_wa),
        .i_wdata(v_wd), .i_raddr(e_ra), .o_rdata(v_rd));
    cht_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_links (.i_clk, .i_we(l_we), .i_waddr(l_wa),
        .i_wdata(l_wd), .i_raddr(e_ra), .o_rdata(l_rd));

    logic [BW-1:0] bkt;
    logic          is_ins, pool_ok;
    logic [PW-1:0] new_slot;
    logic [31:0]   sum;
    assign bkt     = r_key[BW-1:0];
    assign is_ins  = (r_act == ACT_PUT) || (r_act == ACT_PUT_NEW) || (r_act == ACT_INCR);
    assign pool_ok = (r_free != NIL) || (r_unused != NIL);
    assign new_slot = (r_free != NIL) ? r_free : r_unused;
    assign sum     = r_val + (r_found ? v_rd : 32'd0);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b0, r_count, r_status, r_res, r_found};

    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        // head read follows the held key once a request is in flight
        hd_we = 1'b0; hd_wa = bkt; hd_wd = NIL; hd_ra = bkt;
        k_we = 1'b0; v_we = 1'b0; l_we = 1'b0;
        k_wa = new_slot[SW-1:0]; v_wa = new_slot[SW-1:0]; l_wa = new_slot[SW-1:0];
        k_wd = r_key; v_wd = r_val; l_wd = hd_rd;
        e_ra = r_cur[SW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                hd_we = 1'b1; hd_wa = r_clr; hd_wd = NIL;
                if (r_clr == BW'(BUCKETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                hd_ra = s_axis_tdata[3+BW-1:3];
                if (acc) n_state = S_HEAD;
            end
            S_HEAD: n_state = (r_act > ACT_REMOVE) ? S_DONE : S_RD;
            S_RD: begin
                // r_cur valid here; issue entry read
                if (r_cur == NIL || r_steps[SW]) n_state = S_UPD;
                else n_state = S_CMP;
            end
            S_CMP: n_state = (k_rd == r_key) ? S_UPD : S_RD;
            S_UPD: begin
                e_ra = r_cur[SW-1:0];
                if (r_found) begin
                    if (r_act == ACT_PUT || r_act == ACT_INCR) begin
                        v_we = 1'b1; v_wa = r_cur[SW-1:0];
                        v_wd = (r_act == ACT_INCR) ? sum : r_val;
                    end else if (r_act == ACT_REMOVE) begin
                        if (r_prev != NIL) begin
                            l_we = 1'b1; l_wa = r_prev[SW-1:0]; l_wd = l_rd;
                        end else begin
                            hd_we = 1'b1; hd_wd = l_rd;
                        end
                    end
                    n_state = (r_act == ACT_REMOVE) ? S_FREE : S_DONE;
                end else if (is_ins && pool_ok) begin
                    if (r_free != NIL) begin
                        e_ra = r_free[SW-1:0];
                        n_state = S_FREE;
                    end else begin
                        k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
                        v_wd = (r_act == ACT_INCR) ? r_val : r_val;
                        hd_we = 1'b1; hd_wd = new_slot;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                if (r_found) begin
                    l_we = 1'b1; l_wa = r_cur[SW-1:0]; l_wd = r_free;
                end else begin
                    k_we = 1'b1; v_we = 1'b1; l_we = 1'b1;
                    hd_we = 1'b1; hd_wd = new_slot;
                end
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_ovalid <= 1'b0;
            r_free <= NIL; r_unused <= '0; r_count <= '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (acc) begin
                    r_act <= s_axis_tdata[2:0];
                    r_key <= s_axis_tdata[34:3];
                    r_val <= s_axis_tdata[66:35];
                end
                S_HEAD: begin
                    r_cur <= hd_rd; r_prev <= NIL; r_steps <= '0;
                    r_found <= 1'b0; r_status <= 1'b0; r_res <= '0;
                end
                S_RD: ;
                S_CMP: begin
                    if (k_rd == r_key) begin
                        r_found <= 1'b1;
                    end else begin
                        r_prev <= r_cur; r_cur <= l_rd; r_steps <= r_steps + 1'b1;
                    end
                end
                S_UPD: begin
                    if (r_found) begin
                        if (r_act == ACT_PUT) r_res <= r_val;
                        else if (r_act == ACT_INCR) r_res <= sum;
                        else if (r_act == ACT_REMOVE) r_res <= '0;
                        else r_res <= v_rd;
                    end else if (r_act == ACT_GET_ONES) begin
                        r_res <= ALL_ONES;
                    end else if (is_ins) begin
                        if (pool_ok) begin
                            r_res <= r_val;
                            r_count <= r_count + 1'b1;
                            if (r_free == NIL) r_unused <= r_unused + 1'b1;
                        end else begin
                            r_status <= 1'b1;
                        end
                    end
                end
                S_FREE: begin
                    if (r_found) begin
                        r_free <= r_cur;
                        if (r_count != '0) r_count <= r_count - 1'b1;
                    end else begin
                        r_free <= l_rd;
                    end
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

FILE: design/cht_checker.sv
module cht_checker import cht_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("out held");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("busy");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready)) else $error("overlap");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[44:34] <= 11'(ENTRIES)) else $error("count");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[0]) else $error("full");
endmodule

bind chained_hash_table_core cht_checker u_chk (.*);
